// ===== rtl/slf_pkg.sv =====
// shared constants and types for the spot light falloff core
// register map, fixed field widths and the constants used to build the falloff table
// no dependencies
package slf_pkg;

  // fixed field widths
  localparam int DIR_W      = 16;
  localparam int DIST_W     = 32;
  localparam int RESULT_W   = 32;
  localparam int SPAN_CFG_W = 24;
  localparam int GAIN_W     = 24;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;

  // internal widths that follow from the field widths
  localparam int PROD_W  = 2 * DIR_W;            // one direction product
  localparam int DOT_W   = PROD_W + 2;           // negated sum of three products
  localparam int SPAN_W  = 31;                   // clamped d minus lower bound
  localparam int SCALE_W = SPAN_W + SPAN_CFG_W;  // span times inv_span
  localparam int T_SHIFT = 14;
  localparam int T_W     = 33;                   // t in Q1.32, up to 1.0
  localparam logic [T_W-1:0] T_ONE = 33'h1_0000_0000;

  // table construction, Q2.30
  localparam logic [63:0] PI_Q30  = 64'd3373259426;
  localparam logic [63:0] ONE_Q30 = 64'd1073741824;
  localparam int TAYLOR_TERMS = 10;
  localparam logic [15:0] TAYLOR_DEN [TAYLOR_TERMS] = '{
    16'd2, 16'd12, 16'd30, 16'd56, 16'd90, 16'd132, 16'd182, 16'd240, 16'd306, 16'd380
  };

  // register map, byte address 4*index
  typedef enum logic [2:0] {
    REG_AXIS_X,
    REG_AXIS_Y,
    REG_AXIS_Z,
    REG_COS_CONE,
    REG_COS_OUTER,
    REG_INV_SPAN,
    REG_EXPOSURE_GAIN,
    REG_ATTENUATE
  } cfg_reg_e;

endpackage

// ===== rtl/slf_query_if.sv =====
// query channel of the spot light falloff core: valid/ready plus one shading query
// standalone, no package dependency
interface slf_query_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] to_light_x;
  logic signed [15:0] to_light_y;
  logic signed [15:0] to_light_z;
  logic [31:0]        distance_sq;

  modport source (output valid, to_light_x, to_light_y, to_light_z, distance_sq, input ready);
  modport sink (input valid, to_light_x, to_light_y, to_light_z, distance_sq, output ready);
endinterface

// ===== rtl/slf_result_if.sv =====
// result channel of the spot light falloff core: valid/ready plus intensity and clip flag
// standalone, no package dependency
interface slf_result_if;
  logic        valid;
  logic        ready;
  logic [31:0] intensity;
  logic        clipped;

  modport source (output valid, intensity, clipped, input ready);
  modport sink (input valid, intensity, clipped, output ready);
endinterface

// ===== rtl/spot_light_falloff_core.sv =====
// spot light falloff core: cone test, penumbra table lookup, gain and inverse square
// depends on slf_pkg, slf_query_if and slf_result_if

// One shading query is taken in every clock cycle while the pipeline is not held
// up by back-pressure, and each gives one result, in order. The inverse square
// division is a 32-bit restoring divider spread two quotient bits per stage over
// 16 pipeline stages. Every stage holds a valid bit and empty stages close up under
// back-pressure, so queries keep flowing in while empty stages remain and a
// finished result waits on the output. The penumbra curve is a constant table of
// FALLOFF_TABLE_ENTRIES+1 samples built at elaboration and read at two adjacent
// entries for linear interpolation. Registers sit at byte address 4*index and
// must only be written while no query is in flight.
module spot_light_falloff_core import slf_pkg::*; #(
  parameter int FALLOFF_TABLE_ENTRIES = 256,
  parameter int FRACTION_BITS         = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  slf_query_if.sink             query_i,
  slf_result_if.source          result_o,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready
);

  // widths derived from the parameters
  localparam int IDX_W   = $clog2(FALLOFF_TABLE_ENTRIES + 1);
  localparam int POS_W   = 32 + IDX_W;
  localparam int SAMP_W  = FRACTION_BITS + 1;
  localparam int IP_W    = SAMP_W + 34;
  localparam int GP_W    = SAMP_W + GAIN_W;
  localparam int SH_UP   = (FRACTION_BITS < 16) ? 16 - FRACTION_BITS : 0;
  localparam int SH_DN   = (FRACTION_BITS > 16) ? FRACTION_BITS - 16 : 0;
  localparam int NUM_W   = GP_W + SH_UP;
  localparam int DEN_W   = DIST_W + SH_DN;
  localparam int PASS_RND = (1 << SH_DN) >> 1;
  localparam logic [SAMP_W-1:0] F_ONE = SAMP_W'(1) << FRACTION_BITS;

  // stage numbering
  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = RESULT_W / DIV_STEPS;
  localparam int ST_MUL     = 0;
  localparam int ST_DOT     = 1;
  localparam int ST_CLAMP   = 2;
  localparam int ST_SCALE   = 3;
  localparam int ST_T       = 4;
  localparam int ST_POS     = 5;
  localparam int ST_ROM     = 6;
  localparam int ST_IP      = 7;
  localparam int ST_F       = 8;
  localparam int ST_GAIN    = 9;
  localparam int ST_DIVSET  = 10;
  localparam int NSTG       = ST_DIVSET + DIV_STAGES + 2;

  // falloff table, built at elaboration
  typedef logic [SAMP_W-1:0] sample_t;
  typedef sample_t rom_t [FALLOFF_TABLE_ENTRIES + 1];

  function automatic logic [63:0] half_falloff_q30(input int unsigned i);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] c;
    x    = (PI_Q30 * 64'(i)) / 64'(FALLOFF_TABLE_ENTRIES);
    x2   = (x * x) >> 30;
    term = ONE_Q30;
    c    = $signed(ONE_Q30);
    for (int k = 1; k <= TAYLOR_TERMS; k++) begin
      term = ((term * x2) >> 30) / 64'(TAYLOR_DEN[k-1]);
      if (k % 2 == 1) begin
        c = c - $signed(term);
      end else begin
        c = c + $signed(term);
      end
    end
    if (c < 0) begin
      c = '0;
    end
    if (c > $signed(ONE_Q30)) begin
      c = $signed(ONE_Q30);
    end
    return (ONE_Q30 - 64'(c)) >> 1;
  endfunction

  function automatic rom_t build_rom();
    rom_t        r;
    logic [63:0] v;
    for (int i = 0; i <= FALLOFF_TABLE_ENTRIES; i++) begin
      if (2 * i <= FALLOFF_TABLE_ENTRIES) begin
        v = half_falloff_q30(i);
      end else begin
        v = ONE_Q30 - half_falloff_q30(FALLOFF_TABLE_ENTRIES - i);
      end
      r[i] = sample_t'((v + (64'd1 << (29 - FRACTION_BITS))) >> (30 - FRACTION_BITS));
    end
    return r;
  endfunction

  localparam rom_t FALLOFF_ROM = build_rom();

  // configuration registers
  logic signed [DIR_W-1:0] axis_x_q, axis_y_q, axis_z_q;
  logic signed [DIR_W-1:0] cos_cone_q, cos_outer_q;
  logic [SPAN_CFG_W-1:0]   inv_span_q;
  logic [GAIN_W-1:0]       exposure_gain_q;
  logic                    attenuate_q;
  cfg_reg_e                cfg_sel;

  assign cfg_sel = cfg_reg_e'(paddr[CFG_ADDR_W-1:2]);
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      axis_x_q        <= '0;
      axis_y_q        <= '0;
      axis_z_q        <= 16'sh8000;
      cos_cone_q      <= 16'sh7FFF;
      cos_outer_q     <= 16'sh7FFF;
      inv_span_q      <= 24'h01_0000;
      exposure_gain_q <= 24'h01_0000;
      attenuate_q     <= 1'b0;
    end else if (psel && penable && pwrite) begin
      unique case (cfg_sel)
        REG_AXIS_X:        axis_x_q        <= pwdata[DIR_W-1:0];
        REG_AXIS_Y:        axis_y_q        <= pwdata[DIR_W-1:0];
        REG_AXIS_Z:        axis_z_q        <= pwdata[DIR_W-1:0];
        REG_COS_CONE:      cos_cone_q      <= pwdata[DIR_W-1:0];
        REG_COS_OUTER:     cos_outer_q     <= pwdata[DIR_W-1:0];
        REG_INV_SPAN:      inv_span_q      <= pwdata[SPAN_CFG_W-1:0];
        REG_EXPOSURE_GAIN: exposure_gain_q <= pwdata[GAIN_W-1:0];
        REG_ATTENUATE:     attenuate_q     <= pwdata[0];
        default:           attenuate_q     <= attenuate_q;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_AXIS_X:        prdata = CFG_DATA_W'(axis_x_q);
      REG_AXIS_Y:        prdata = CFG_DATA_W'(axis_y_q);
      REG_AXIS_Z:        prdata = CFG_DATA_W'(axis_z_q);
      REG_COS_CONE:      prdata = CFG_DATA_W'(cos_cone_q);
      REG_COS_OUTER:     prdata = CFG_DATA_W'(cos_outer_q);
      REG_INV_SPAN:      prdata = CFG_DATA_W'(inv_span_q);
      REG_EXPOSURE_GAIN: prdata = CFG_DATA_W'(exposure_gain_q);
      REG_ATTENUATE:     prdata = CFG_DATA_W'(attenuate_q);
      default:           prdata = '0;
    endcase
  end

  // pipeline control: a stage loads when it is empty or its successor moves
  logic [NSTG-1:0] valid_q;
  logic [NSTG-1:0] en;

  assign en[NSTG-1] = !valid_q[NSTG-1] || result_o.ready;
  for (genvar s = 0; s < NSTG - 1; s++) begin : g_en
    assign en[s] = !valid_q[s] || en[s+1];
  end

  assign query_i.ready = en[0];
  assign result_o.valid = valid_q[NSTG-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      if (en[0]) begin
        valid_q[0] <= query_i.valid;
      end
      for (int s = 1; s < NSTG; s++) begin
        if (en[s]) begin
          valid_q[s] <= valid_q[s-1];
        end
      end
    end
  end

  // side data carried along the front stages
  logic [DIST_W-1:0] dist_q [ST_MUL:ST_GAIN];
  logic              soft_q [ST_CLAMP:ST_IP];
  logic              ge_q   [ST_CLAMP:ST_IP];

  always_ff @(posedge clk_i) begin
    if (en[ST_MUL]) begin
      dist_q[ST_MUL] <= query_i.distance_sq;
    end
    for (int s = ST_MUL + 1; s <= ST_GAIN; s++) begin
      if (en[s]) begin
        dist_q[s] <= dist_q[s-1];
      end
    end
  end

  // direction products
  logic signed [PROD_W-1:0] px_q, py_q, pz_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_MUL]) begin
      px_q <= query_i.to_light_x * axis_x_q;
      py_q <= query_i.to_light_y * axis_y_q;
      pz_q <= query_i.to_light_z * axis_z_q;
    end
  end

  // d = -(to_light . axis), exact in Q2.30
  logic signed [DOT_W-1:0] dot_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_DOT]) begin
      dot_q <= DOT_W'(0) - (DOT_W'(px_q) + DOT_W'(py_q) + DOT_W'(pz_q));
    end
  end

  // clamp into the penumbra and take the offset from the outer cosine
  logic signed [DOT_W-1:0] hi_s, lo_s, span_full, span_part;
  logic [SPAN_W-1:0]       span_d, span_q;

  always_comb begin
    hi_s      = {{(DOT_W - DIR_W - 15){cos_cone_q[DIR_W-1]}}, cos_cone_q, 15'd0};
    lo_s      = {{(DOT_W - DIR_W - 15){cos_outer_q[DIR_W-1]}}, cos_outer_q, 15'd0};
    span_full = hi_s - lo_s;
    span_part = dot_q - lo_s;
    priority if (dot_q > hi_s) begin
      span_d = span_full[SPAN_W-1:0];
    end else if (dot_q < lo_s) begin
      span_d = '0;
    end else begin
      span_d = span_part[SPAN_W-1:0];
    end
  end

  // edge flags travel with the transaction up to the interpolation stage
  always_ff @(posedge clk_i) begin
    if (en[ST_CLAMP]) begin
      span_q           <= span_d;
      soft_q[ST_CLAMP] <= cos_cone_q > cos_outer_q;
      ge_q[ST_CLAMP]   <= dot_q >= hi_s;
    end
    for (int s = ST_CLAMP + 1; s <= ST_IP; s++) begin
      if (en[s]) begin
        soft_q[s] <= soft_q[s-1];
        ge_q[s]   <= ge_q[s-1];
      end
    end
  end

  // scale by the reciprocal span
  logic [SCALE_W-1:0] scale_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_SCALE]) begin
      scale_q <= SCALE_W'(span_q) * SCALE_W'(inv_span_q);
    end
  end

  // t in Q1.32, saturated at one for a mis-set inv_span
  logic [T_W-1:0] t_q;
  logic [SCALE_W-T_SHIFT-1:0] t_raw;

  assign t_raw = scale_q[SCALE_W-1:T_SHIFT];

  always_ff @(posedge clk_i) begin
    if (en[ST_T]) begin
      t_q <= (t_raw > (SCALE_W - T_SHIFT)'(T_ONE)) ? T_ONE : T_W'(t_raw);
    end
  end

  // table position: integer part selects the entry, low 32 bits weight it
  logic [POS_W-1:0] pos;
  logic [IDX_W-1:0] idx_q;
  logic [31:0]      frac_pos_q;
  logic             full_pos_q;

  assign pos = POS_W'(t_q) * POS_W'(FALLOFF_TABLE_ENTRIES);

  always_ff @(posedge clk_i) begin
    if (en[ST_POS]) begin
      idx_q      <= pos[POS_W-1:32];
      frac_pos_q <= pos[31:0];
      full_pos_q <= pos[POS_W-1:32] == IDX_W'(FALLOFF_TABLE_ENTRIES);
    end
  end

  // table read at two adjacent entries
  logic [IDX_W-1:0]  addr_a, addr_b;
  logic [SAMP_W-1:0] samp_a_q, samp_b_q;
  logic [31:0]       frac_rom_q;
  logic              full_rom_q;

  assign addr_a = full_pos_q ? IDX_W'(FALLOFF_TABLE_ENTRIES - 1) : idx_q;
  assign addr_b = addr_a + IDX_W'(1);

  always_ff @(posedge clk_i) begin
    if (en[ST_ROM]) begin
      samp_a_q   <= FALLOFF_ROM[addr_a];
      samp_b_q   <= FALLOFF_ROM[addr_b];
      frac_rom_q <= frac_pos_q;
      full_rom_q <= full_pos_q;
    end
  end

  // interpolation: a + (b - a) * frac, with the top entry taken whole at t = 1
  logic signed [SAMP_W:0]   samp_diff;
  logic [31:0]              frac_eff;
  logic signed [IP_W-1:0]   ip_q;
  logic [SAMP_W-1:0]        base_q;

  assign samp_diff = $signed({1'b0, samp_b_q}) - $signed({1'b0, samp_a_q});
  assign frac_eff  = full_rom_q ? '0 : frac_rom_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_IP]) begin
      ip_q   <= samp_diff * $signed({1'b0, frac_eff});
      base_q <= full_rom_q ? samp_b_q : samp_a_q;
    end
  end

  // falloff in Q1.FRACTION_BITS
  logic signed [IP_W-1:0] ip_rnd, f_soft;
  logic [SAMP_W-1:0]      f_d, f_q;

  always_comb begin
    ip_rnd = (ip_q + $signed(IP_W'(64'h8000_0000))) >>> 32;
    f_soft = $signed(IP_W'(base_q)) + ip_rnd;
    if (soft_q[ST_IP]) begin
      f_d = f_soft[SAMP_W-1:0];
    end else begin
      f_d = ge_q[ST_IP] ? F_ONE : '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[ST_F]) begin
      f_q <= f_d;
    end
  end

  // gain product and the unattenuated result
  logic [GP_W-1:0]     gp_q;
  logic [RESULT_W-1:0] pass_gain_q;

  always_ff @(posedge clk_i) begin
    if (en[ST_GAIN]) begin
      gp_q        <= GP_W'(f_q) * GP_W'(exposure_gain_q);
      pass_gain_q <= ((RESULT_W'(f_q) + RESULT_W'(PASS_RND)) >> SH_DN) << SH_UP;
    end
  end

  // divider set-up: overflow when the quotient would need more than 32 bits
  logic [NUM_W-1:0]    num;
  logic [DEN_W-1:0]    den;
  logic [DEN_W-1:0]    num_top;

  logic [DEN_W-1:0]    rem_q  [DIV_STAGES+1];
  logic [DEN_W-1:0]    den_q  [DIV_STAGES+1];
  logic [RESULT_W-1:0] lq_q   [DIV_STAGES+1];
  logic [RESULT_W-1:0] pass_q [DIV_STAGES+1];
  logic                att_q  [DIV_STAGES+1];
  logic                ovf_q  [DIV_STAGES+1];

  assign num     = NUM_W'(gp_q) << SH_UP;
  assign den     = DEN_W'(dist_q[ST_GAIN]) << SH_DN;
  assign num_top = DEN_W'(num[NUM_W-1:RESULT_W]);

  always_ff @(posedge clk_i) begin
    if (en[ST_DIVSET]) begin
      rem_q[0]  <= num_top;
      den_q[0]  <= den;
      lq_q[0]   <= num[RESULT_W-1:0];
      pass_q[0] <= pass_gain_q;
      att_q[0]  <= attenuate_q;
      ovf_q[0]  <= num_top >= den;
    end
  end

  // restoring division, low dividend bits shift out as quotient bits shift in
  for (genvar j = 1; j <= DIV_STAGES; j++) begin : g_div
    logic [DEN_W-1:0]    rem_d;
    logic [RESULT_W-1:0] lq_d;

    always_comb begin
      logic [DEN_W:0] trial;
      rem_d = rem_q[j-1];
      lq_d  = lq_q[j-1];
      for (int k = 0; k < DIV_STEPS; k++) begin
        trial = {rem_d, lq_d[RESULT_W-1]};
        lq_d  = {lq_d[RESULT_W-2:0], 1'b0};
        if (trial >= {1'b0, den_q[j-1]}) begin
          trial   = trial - {1'b0, den_q[j-1]};
          lq_d[0] = 1'b1;
        end
        rem_d = trial[DEN_W-1:0];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en[ST_DIVSET+j]) begin
        rem_q[j]  <= rem_d;
        den_q[j]  <= den_q[j-1];
        lq_q[j]   <= lq_d;
        pass_q[j] <= pass_q[j-1];
        att_q[j]  <= att_q[j-1];
        ovf_q[j]  <= ovf_q[j-1];
      end
    end
  end

  // output register
  logic [RESULT_W-1:0] intensity_q;
  logic                clipped_q;

  always_ff @(posedge clk_i) begin
    if (en[NSTG-1]) begin
      clipped_q <= att_q[DIV_STAGES] && ovf_q[DIV_STAGES];
      if (!att_q[DIV_STAGES]) begin
        intensity_q <= pass_q[DIV_STAGES];
      end else if (ovf_q[DIV_STAGES]) begin
        intensity_q <= '1;
      end else begin
        intensity_q <= lq_q[DIV_STAGES];
      end
    end
  end

  assign result_o.intensity = intensity_q;
  assign result_o.clipped   = clipped_q;

`ifndef SYNTHESIS
  // an accepted transaction always lands in the first stage
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    query_i.valid && query_i.ready |=> valid_q[ST_MUL])
    else $error("accepted transaction missing from first stage");

  // interpolated falloff never exceeds one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_q[ST_F] |-> f_q <= F_ONE)
    else $error("falloff above one");

  // a clipped result is always the saturated value
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_o.valid && result_o.clipped |-> result_o.intensity == '1)
    else $error("clipped result not saturated");
`endif

endmodule

// ===== verif/slf_checker.sv =====
// checker for the spot light falloff core: watches the query, result and register ports
// predicts every intensity from its own register copy and penumbra table, then compares
// depends on slf_pkg, slf_query_if and slf_result_if
module slf_checker import slf_pkg::*; #(
  parameter int TABLE_N   = 256,
  parameter int FRAC_BITS = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  slf_query_if                  query_i,
  slf_result_if                 result_i,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic                  pready,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output int                    errors_o,
  output int                    pending_o
);

  typedef struct packed {
    logic [RESULT_W-1:0] intensity;
    logic                clipped;
  } light_result_t;

  localparam logic [63:0] PI_FIX  = 64'd3373259426;
  localparam longint      ONE_FIX = 1073741824;

  logic [31:0]        penumbra_rom [TABLE_N+1];
  logic signed [15:0] axis_x, axis_y, axis_z, cos_cone, cos_outer;
  logic [23:0]        inv_span, exposure_gain;
  logic               attenuate;
  light_result_t      expected_q [$];

  // half of one minus cos(pi*i/N) in Q2.30, truncated series
  function automatic longint raised_cos_q30(int unsigned i);
    logic [63:0] x, x2, term;
    longint      c;
    x    = (PI_FIX * i) / TABLE_N;
    x2   = (x * x) >> 30;
    term = 64'(ONE_FIX);
    c    = ONE_FIX;
    for (int k = 1; k <= 10; k++) begin
      term = ((term * x2) >> 30) / ((2 * k - 1) * (2 * k));
      if (k % 2 == 1) begin
        c = c - longint'(term);
      end else begin
        c = c + longint'(term);
      end
    end
    if (c < 0) c = 0;
    if (c > ONE_FIX) c = ONE_FIX;
    return (ONE_FIX - c) / 2;
  endfunction

  initial begin
    longint v;
    for (int i = 0; i <= TABLE_N; i++) begin
      // upper half mirrored from the lower half
      if (2 * i <= TABLE_N) begin
        v = raised_cos_q30(i);
      end else begin
        v = ONE_FIX - raised_cos_q30(TABLE_N - i);
      end
      penumbra_rom[i] = 32'((64'(v) + (64'd1 << (29 - FRAC_BITS))) >> (30 - FRAC_BITS));
    end
  end

  function automatic light_result_t predict_light(logic signed [15:0] x, y, z,
                                                  logic [31:0] dist_sq);
    longint        d, hi, lo;
    logic [63:0]   span, t, pos, idx, frac, f, prod, quot;
    light_result_t r;
    d  = -(longint'(x) * axis_x + longint'(y) * axis_y + longint'(z) * axis_z);
    hi = longint'(cos_cone) * 32768;
    lo = longint'(cos_outer) * 32768;
    r.clipped = 1'b0;
    if (cos_cone > cos_outer) begin
      if (d > hi) d = hi;
      if (d < lo) d = lo;
      span = d - lo;
      t    = (span * inv_span) >> 14;
      if (t > 64'h1_0000_0000) t = 64'h1_0000_0000;
      pos  = t * TABLE_N;
      idx  = pos >> 32;
      frac = {32'd0, pos[31:0]};
      if (idx >= TABLE_N) begin
        f = penumbra_rom[TABLE_N];
      end else begin
        f = (64'(penumbra_rom[idx]) * (64'h1_0000_0000 - frac)
             + 64'(penumbra_rom[idx + 1]) * frac + 64'h8000_0000) >> 32;
      end
    end else begin
      // hard edge, also when the cosines are inverted
      f = (d >= hi) ? (64'd1 << FRAC_BITS) : 64'd0;
    end
    if (attenuate) begin
      prod = f * exposure_gain;
      if (dist_sq == 32'd0) begin
        quot      = 64'hFFFF_FFFF;
        r.clipped = 1'b1;
      end else begin
        if (FRAC_BITS <= 16) begin
          quot = (prod << (16 - FRAC_BITS)) / dist_sq;
        end else begin
          quot = prod / (64'(dist_sq) << (FRAC_BITS - 16));
        end
        if (quot > 64'hFFFF_FFFF) begin
          quot      = 64'hFFFF_FFFF;
          r.clipped = 1'b1;
        end
      end
    end else if (FRAC_BITS > 16) begin
      quot = (f + (64'd1 << (FRAC_BITS - 17))) >> (FRAC_BITS - 16);
    end else begin
      quot = f << (16 - FRAC_BITS);
    end
    r.intensity = quot[31:0];
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    light_result_t want;
    if (!rst_ni) begin
      axis_x        = 16'sd0;
      axis_y        = 16'sd0;
      axis_z        = -16'sd32768;
      cos_cone      = 16'sd32767;
      cos_outer     = 16'sd32767;
      inv_span      = 24'h01_0000;
      exposure_gain = 24'h01_0000;
      attenuate     = 1'b0;
      expected_q.delete();
      errors_o      = 0;
    end else begin
      if (psel && penable && pwrite && pready) begin
        case (cfg_reg_e'(paddr[4:2]))
          REG_AXIS_X:        axis_x        = pwdata[15:0];
          REG_AXIS_Y:        axis_y        = pwdata[15:0];
          REG_AXIS_Z:        axis_z        = pwdata[15:0];
          REG_COS_CONE:      cos_cone      = pwdata[15:0];
          REG_COS_OUTER:     cos_outer     = pwdata[15:0];
          REG_INV_SPAN:      inv_span      = pwdata[23:0];
          REG_EXPOSURE_GAIN: exposure_gain = pwdata[23:0];
          REG_ATTENUATE:     attenuate     = pwdata[0];
          default: ;
        endcase
      end
      if (query_i.valid && query_i.ready) begin
        expected_q.push_back(predict_light(query_i.to_light_x, query_i.to_light_y,
                                           query_i.to_light_z, query_i.distance_sq));
      end
      if (result_i.valid && result_i.ready) begin
        if (expected_q.size() == 0) begin
          $display("%0t: result transaction with none expected, intensity %h clipped %b",
                   $time, result_i.intensity, result_i.clipped);
          errors_o++;
        end else begin
          want = expected_q.pop_front();
          if (result_i.intensity !== want.intensity) begin
            $display("%0t: intensity expected %h, actual %h",
                     $time, want.intensity, result_i.intensity);
            errors_o++;
          end
          if (result_i.clipped !== want.clipped) begin
            $display("%0t: clipped expected %b, actual %b",
                     $time, want.clipped, result_i.clipped);
            errors_o++;
          end
        end
      end
    end
    pending_o = expected_q.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// top of the spot light falloff testbench: clock, reset, register writes and query stimulus
// depends on slf_pkg, both channel interfaces, spot_light_falloff_core and slf_checker
module tb_top;
  import slf_pkg::*;

  localparam int TABLE_N   = 256;
  localparam int FRAC_BITS = 16;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  psel, penable, pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata, prdata;
  logic                  pready;
  int                    idle_pct, stall_pct, errors, pending;
  logic signed [15:0]    aim_x, aim_y, aim_z;

  slf_query_if  query_bus ();
  slf_result_if result_bus ();

  spot_light_falloff_core #(
    .FALLOFF_TABLE_ENTRIES(TABLE_N),
    .FRACTION_BITS        (FRAC_BITS)
  ) dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .query_i (query_bus),
    .result_o(result_bus),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  slf_checker #(
    .TABLE_N  (TABLE_N),
    .FRAC_BITS(FRAC_BITS)
  ) light_checker (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .query_i  (query_bus),
    .result_i (result_bus),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .pready   (pready),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .errors_o (errors),
    .pending_o(pending)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      result_bus.ready = 1'b0;
    end else begin
      result_bus.ready = ($urandom_range(99) >= stall_pct);
    end
  end

  task automatic write_light_reg(input cfg_reg_e r, input logic [31:0] value);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = {r, 2'b00};
    pwdata  = value;
    @(negedge clk);
    penable = 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // drop valid, let every query drain, then allow for the pipeline depth
  task automatic wait_drained();
    query_bus.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (32) @(negedge clk);
  endtask

  task automatic load_light_setup(input logic signed [15:0] ax, ay, az, input int cone,
                                  input int outer, input logic [23:0] span, gain,
                                  input logic att);
    wait_drained();
    write_light_reg(REG_AXIS_X, 32'(ax));
    write_light_reg(REG_AXIS_Y, 32'(ay));
    write_light_reg(REG_AXIS_Z, 32'(az));
    write_light_reg(REG_COS_CONE, 32'(cone));
    write_light_reg(REG_COS_OUTER, 32'(outer));
    write_light_reg(REG_INV_SPAN, {8'd0, span});
    write_light_reg(REG_EXPOSURE_GAIN, {8'd0, gain});
    write_light_reg(REG_ATTENUATE, {31'd0, att});
    aim_x = ax;
    aim_y = ay;
    aim_z = az;
  endtask

  // reciprocal of the penumbra width in Q8.16, saturated to the register
  function automatic logic [23:0] span_for(int cone, int outer);
    longint q;
    if (cone <= outer) return 24'h01_0000;
    q = longint'(2147483648) / longint'(cone - outer);
    if (q > 24'hFF_FFFF) q = 24'hFF_FFFF;
    return q[23:0];
  endfunction

  task automatic send_query(input logic signed [15:0] x, y, z, input logic [31:0] dist_sq);
    while ($urandom_range(99) < idle_pct) begin
      query_bus.valid = 1'b0;
      @(negedge clk);
    end
    query_bus.valid       = 1'b1;
    query_bus.to_light_x  = x;
    query_bus.to_light_y  = y;
    query_bus.to_light_z  = z;
    query_bus.distance_sq = dist_sq;
    do @(posedge clk); while (!query_bus.ready);
    @(negedge clk);
  endtask

  // component pointing back along the axis, with some scatter
  function automatic logic signed [15:0] toward_axis(logic signed [15:0] a, int spread);
    int v;
    v = -int'(a) + int'($urandom_range(2 * spread)) - spread;
    if (v > 32767) v = 32767;
    if (v < -32768) v = -32768;
    return 16'(v);
  endfunction

  function automatic logic [31:0] pick_distance();
    case ($urandom_range(19))
      0: return 32'd0;
      1: return 32'hFFFF_FFFF;
      2, 3, 4, 5, 6, 7: return $urandom;
      default: return $urandom_range(32'h0004_0000, 1);
    endcase
  endfunction

  task automatic send_random_query();
    int                 spread;
    logic signed [15:0] x, y, z;
    if ($urandom_range(9) < 6) begin
      case ($urandom_range(2))
        0: spread = 600;
        1: spread = 4000;
        default: spread = 16000;
      endcase
      x = toward_axis(aim_x, spread);
      y = toward_axis(aim_y, spread);
      z = toward_axis(aim_z, spread);
    end else begin
      x = 16'($urandom);
      y = 16'($urandom);
      z = 16'($urandom);
    end
    send_query(x, y, z, pick_distance());
  endtask

  task automatic random_light_setup();
    logic signed [15:0] ax, ay, az;
    int                 cone, outer;
    logic [23:0]        span, gain;
    case ($urandom_range(3))
      0: begin
        ax = 16'sd0; ay = 16'sd0; az = -16'sd32768;
      end
      1: begin
        ax = 16'sd32767; ay = 16'sd0; az = 16'sd0;
      end
      2: begin
        ax = 16'sd18919; ay = -16'sd18919; az = 16'sd18919;
      end
      default: begin
        ax = 16'($urandom); ay = 16'($urandom); az = 16'($urandom);
      end
    endcase
    case ($urandom_range(5))
      0: begin
        outer = int'($urandom_range(65468)) - 32768;
        cone  = outer + 1 + int'($urandom_range(32766 - outer));
        span  = span_for(cone, outer);
      end
      1: begin
        // penumbra with an unrelated reciprocal
        outer = int'($urandom_range(65468)) - 32768;
        cone  = outer + 1 + int'($urandom_range(32766 - outer));
        span  = 24'($urandom);
      end
      2: begin
        outer = int'($urandom_range(65535)) - 32768;
        cone  = outer;
        span  = 24'($urandom);
      end
      3: begin
        cone  = int'($urandom_range(65534)) - 32768;
        outer = cone + 1 + int'($urandom_range(32766 - cone));
        span  = 24'($urandom);
      end
      4: begin
        cone  = 32767;
        outer = -32768;
        span  = span_for(cone, outer);
      end
      default: begin
        outer = int'($urandom_range(65468)) - 32768;
        cone  = outer + 1 + int'($urandom_range(63));
        span  = span_for(cone, outer);
      end
    endcase
    case ($urandom_range(3))
      0: gain = 24'h01_0000;
      1: gain = 24'($urandom);
      2: gain = 24'hFF_FFFF;
      default: gain = 24'($urandom_range(512));
    endcase
    load_light_setup(ax, ay, az, cone, outer, span, gain, 1'($urandom_range(1)));
  endtask

  initial begin
    rst_n                 = 1'b0;
    psel                  = 1'b0;
    penable               = 1'b0;
    pwrite                = 1'b0;
    paddr                 = '0;
    pwdata                = '0;
    query_bus.valid       = 1'b0;
    query_bus.to_light_x  = '0;
    query_bus.to_light_y  = '0;
    query_bus.to_light_z  = '0;
    query_bus.distance_sq = '0;
    result_bus.ready      = 1'b0;
    idle_pct              = 0;
    stall_pct             = 0;
    aim_x                 = 16'sd0;
    aim_y                 = 16'sd0;
    aim_z                 = -16'sd32768;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // reset setup: hard edge along the axis, distance ignored
    send_query(0, 0, 32767, 32'd0);
    send_query(0, 0, -32768, 32'hFFFF_FFFF);
    send_query(-32768, -32768, -32768, 32'h8000_0000);
    send_query(32767, 32767, 32767, 32'd1);

    // soft edge with gain and inverse square
    load_light_setup(0, 0, -32768, 29491, 22938, span_for(29491, 22938), 24'h01_0000, 1'b1);
    send_query(0, 0, 32767, 32'h0001_0000);
    send_query(0, 0, 32767, 32'd0);
    send_query(0, 0, 32767, 32'd1);
    send_query(0, 0, 0, 32'h0001_0000);
    send_query(0, 0, 26000, 32'h0001_0000);
    send_query(0, 9000, 24000, 32'h0000_8000);
    send_query(0, 0, 23500, 32'hFFFF_FFFF);
    send_query(-32768, -32768, -32768, 32'h0000_4000);

    // inverted cosines fall back to a hard edge, maximum gain
    load_light_setup(0, 0, -32768, -32768, 32767, 24'h00_0000, 24'hFF_FFFF, 1'b1);
    send_query(0, 0, 32767, 32'd1);
    send_query(0, 0, -32768, 32'h0000_0100);
    send_query(32767, 0, 0, 32'hFFFF_FFFF);

    // reciprocal far too large: position saturates at the top of the table
    load_light_setup(32767, 0, 0, 32767, -32768, 24'hFF_FFFF, 24'h00_0000, 1'b0);
    send_query(-32768, 0, 0, 32'h0000_0000);
    send_query(0, 0, 0, 32'h1234_5678);
    send_query(-16000, 5000, 0, 32'h0000_0001);

    // zero reciprocal keeps the position at the bottom
    load_light_setup(0, -32768, 0, 16384, -16384, 24'h00_0000, 24'h00_8000, 1'b1);
    send_query(0, 32767, 0, 32'h0000_0001);
    send_query(0, 0, 0, 32'h0002_0000);

    for (int p = 0; p < 8; p++) begin
      random_light_setup();
      case (p % 4)
        0: begin
          idle_pct = 0; stall_pct = 0;
        end
        1: begin
          idle_pct = 69; stall_pct = 0;
        end
        2: begin
          idle_pct = 0; stall_pct = 69;
        end
        default: begin
          idle_pct = 28; stall_pct = 28;
        end
      endcase
      repeat (50) send_random_query();
    end

    wait_drained();
    if (errors == 0) begin
      $display("tb_top: done, clean");
    end else begin
      $display("tb_top: done, errors");
    end
    $finish;
  end

  initial begin
    #4000000;
    $display("tb_top: done, errors");
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/slf_pkg.sv
rtl/slf_query_if.sv
rtl/slf_result_if.sv
rtl/spot_light_falloff_core.sv
verif/slf_checker.sv
verif/tb_top.sv
